@@ sv/round_robin_multi_stack_drain_unit_defines.svh @@
// assertion macros for the round-robin multi-stack drain unit
// used by the port checker; no other dependencies
`ifndef ROUND_ROBIN_MULTI_STACK_DRAIN_UNIT_DEFINES_SVH
`define ROUND_ROBIN_MULTI_STACK_DRAIN_UNIT_DEFINES_SVH

// property checked only out of reset
`define RRMSD_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// property checked at every edge, reset included
`define RRMSD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ sv/rrmsd_pkg.sv @@
// shared types and constants of the round-robin multi-stack drain unit
// no dependencies
package rrmsd_pkg;

  localparam int QID_W  = 3;
  localparam int REF_W  = 32;
  localparam int SLOT_W = 10;
  localparam int CNT_W  = 32;
  localparam int AQ_W   = 4;
  localparam int REQ_W  = 2;
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 72;

  localparam logic [CNT_W-1:0] DROP_MAX = '1;

  // request codes on the input tuser
  localparam logic [REQ_W-1:0] REQ_PUSH  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_POP   = 2'd1;
  localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;

  // classified operation handed to the engine
  typedef enum logic [1:0] {
    OP_PUSH  = 2'd0,
    OP_POP   = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NOP   = 2'd3
  } op_e;

  typedef struct packed {
    op_e               op;
    logic [QID_W-1:0]  queue_id;
    logic [REF_W-1:0]  ref_value;
    logic [SLOT_W-1:0] slot_index;
  } cmd_t;

  // queue to engine handshake
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_chan_t;

  typedef struct packed {
    logic [CNT_W-1:0] drop_count;
    logic             all_empty;
    logic             push_accepted;
    logic             found;
    logic [REF_W-1:0] popped_ref;
  } rsp_t;

endpackage

@@ sv/rrmsd_front.sv @@
// front end: unpacks input items and classifies them into engine commands
// depends on rrmsd_pkg
module rrmsd_front #(
  parameter int CW = 4
) (
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // queue_id [2:0], ref_value [34:3], slot_index [44:35], zero fill
  input  logic [rrmsd_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  // req_type [1:0]
  input  logic [rrmsd_pkg::REQ_W-1:0]         s_axis_tuser,
  input  logic [CW-1:0]                       live_count_i,
  input  logic                                fifo_full_i,
  output logic                                fifo_push_o,
  output rrmsd_pkg::cmd_t                     fifo_cmd_o
);

  logic [rrmsd_pkg::QID_W-1:0] qid;
  logic                        q_live;

  assign qid           = s_axis_tdata[2:0];
  assign q_live        = 32'(qid) < 32'(live_count_i);
  assign s_axis_tready = !fifo_full_i;
  assign fifo_push_o   = s_axis_tvalid && !fifo_full_i;

  // classify; push or clear to an inactive stack and unused codes do nothing
  always_comb begin
    fifo_cmd_o.queue_id   = qid;
    fifo_cmd_o.ref_value  = s_axis_tdata[34:3];
    fifo_cmd_o.slot_index = s_axis_tdata[44:35];
    if (s_axis_tuser == rrmsd_pkg::REQ_PUSH && q_live) begin
      fifo_cmd_o.op = rrmsd_pkg::OP_PUSH;
    end else if (s_axis_tuser == rrmsd_pkg::REQ_POP) begin
      fifo_cmd_o.op = rrmsd_pkg::OP_POP;
    end else if (s_axis_tuser == rrmsd_pkg::REQ_CLEAR && q_live) begin
      fifo_cmd_o.op = rrmsd_pkg::OP_CLEAR;
    end else begin
      fifo_cmd_o.op = rrmsd_pkg::OP_NOP;
    end
  end

endmodule

@@ sv/rrmsd_cmd_fifo.sv @@
// two-entry command queue between front end and engine
// depends on rrmsd_pkg
module rrmsd_cmd_fifo (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  rrmsd_pkg::cmd_t      cmd_i,
  output logic                 full_o,
  output rrmsd_pkg::cmd_chan_t head_o,
  input  logic                 pop_i
);

  rrmsd_pkg::cmd_t entry_q [2];
  logic            wr_ptr_q, wr_ptr_d;
  logic            rd_ptr_q, rd_ptr_d;
  logic [1:0]      count_q, count_d;
  logic            do_push, do_pop;

  assign full_o       = count_q == 2'd2;
  assign head_o.valid = count_q != 2'd0;
  assign head_o.cmd   = entry_q[rd_ptr_q];
  assign do_push      = push_i && !full_o;
  assign do_pop       = pop_i && head_o.valid;

  // pointers and fill level
  always_comb begin
    wr_ptr_d = do_push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? !rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 2'd1;
    end else if (!do_push && do_pop) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // payload storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

@@ sv/rrmsd_back.sv @@
// engine: stack memory, heights, drain cursor, flags and result register
// depends on rrmsd_pkg
module rrmsd_back #(
  parameter int NUM_QUEUES  = 8,
  parameter int QUEUE_DEPTH = 1024,
  parameter int CW          = 4
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic [CW-1:0]                    live_count_i,
  input  rrmsd_pkg::cmd_chan_t             head_i,
  output logic                             pop_o,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output rrmsd_pkg::rsp_t                  rsp_o
);

  localparam int QW     = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int HW     = $clog2(QUEUE_DEPTH + 1);
  localparam int ENTRIES = NUM_QUEUES * QUEUE_DEPTH;
  localparam int AW     = $clog2(ENTRIES);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EXEC = 4'b0010,
    S_WALK = 4'b0100,
    S_TEST = 4'b1000
  } state_e;

  state_e                      state_q, state_d;
  rrmsd_pkg::cmd_t             cmd_q, cmd_d;
  logic [QW-1:0]               cursor_q, cursor_d;
  logic [CW-1:0]               tries_q, tries_d;
  logic [HW-1:0]               height_q [NUM_QUEUES];
  logic [HW-1:0]               height_d [NUM_QUEUES];
  logic                        empty_q, empty_d;
  logic [rrmsd_pkg::CNT_W-1:0] drop_q, drop_d;
  logic                        out_valid_q, out_valid_d;
  rrmsd_pkg::rsp_t             out_q, out_d;

  logic [rrmsd_pkg::REF_W-1:0] stack_mem [ENTRIES];
  logic [rrmsd_pkg::REF_W-1:0] rd_data_q;
  logic                        mem_we, mem_re;
  logic [AW-1:0]               mem_waddr, mem_raddr;
  logic [rrmsd_pkg::REF_W-1:0] mem_wdata;

  logic [QW+rrmsd_pkg::QID_W-1:0] qid_ext;
  logic [QW-1:0]               sel;
  logic [HW-1:0]               sel_h;
  logic                        take;

  assign qid_ext       = {{QW{1'b0}}, cmd_q.queue_id};
  assign sel           = (state_q == S_WALK) ? cursor_q : qid_ext[QW-1:0];
  assign sel_h         = height_q[sel];
  assign take          = (state_q == S_IDLE) && head_i.valid &&
                         (!out_valid_q || m_axis_tready);
  assign pop_o         = take;
  assign m_axis_tvalid = out_valid_q;
  assign rsp_o         = out_q;

  // command sequencing and state update
  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    cursor_d    = cursor_q;
    tries_d     = tries_q;
    height_d    = height_q;
    empty_d     = empty_q;
    drop_d      = drop_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_d       = out_q;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    mem_waddr   = '0;
    mem_raddr   = '0;
    mem_wdata   = '0;

    unique case (state_q)
      S_IDLE: begin
        if (take) begin
          cmd_d   = head_i.cmd;
          tries_d = '0;
          state_d = S_EXEC;
        end
      end

      S_EXEC: begin
        state_d                 = S_IDLE;
        out_d.popped_ref        = '0;
        out_d.found             = 1'b0;
        out_d.push_accepted     = 1'b0;
        unique case (cmd_q.op)
          rrmsd_pkg::OP_PUSH: begin
            if (32'(sel_h) < QUEUE_DEPTH) begin
              mem_we              = 1'b1;
              mem_waddr           = AW'(sel) * AW'(QUEUE_DEPTH) + AW'(sel_h);
              mem_wdata           = cmd_q.ref_value;
              height_d[sel]       = sel_h + HW'(1);
              empty_d             = 1'b0;
              out_d.push_accepted = 1'b1;
            end else if (drop_q != rrmsd_pkg::DROP_MAX) begin
              drop_d = drop_q + rrmsd_pkg::CNT_W'(1);
            end
          end
          rrmsd_pkg::OP_CLEAR: begin
            if (32'(cmd_q.slot_index) < 32'(sel_h)) begin
              mem_we    = 1'b1;
              mem_waddr = AW'(sel) * AW'(QUEUE_DEPTH) + AW'(cmd_q.slot_index);
            end
          end
          rrmsd_pkg::OP_POP: begin
            // stale cursor after a shrink of the active count restarts at 0
            if (32'(cursor_q) >= 32'(live_count_i)) begin
              cursor_d = '0;
            end
            state_d = S_WALK;
          end
          default: begin
          end
        endcase
        if (cmd_q.op != rrmsd_pkg::OP_POP) begin
          out_valid_d      = 1'b1;
          out_d.all_empty  = empty_d;
          out_d.drop_count = drop_d;
        end
      end

      // take the top of the stack under the cursor, or move to the next stack
      S_WALK: begin
        if (sel_h != '0) begin
          height_d[sel] = sel_h - HW'(1);
          mem_re        = 1'b1;
          mem_raddr     = AW'(sel) * AW'(QUEUE_DEPTH) + AW'(sel_h - HW'(1));
          state_d       = S_TEST;
        end else begin
          if (32'(cursor_q) + 32'd1 == 32'(live_count_i)) begin
            cursor_d = '0;
          end else begin
            cursor_d = QW'(32'(cursor_q) + 32'd1);
          end
          if (CW'(tries_q + CW'(1)) == live_count_i) begin
            empty_d             = 1'b1;
            out_valid_d         = 1'b1;
            out_d.popped_ref    = '0;
            out_d.found         = 1'b0;
            out_d.push_accepted = 1'b0;
            out_d.all_empty     = 1'b1;
            out_d.drop_count    = drop_q;
            state_d             = S_IDLE;
          end else begin
            tries_d = tries_q + CW'(1);
          end
        end
      end

      // null entries are skipped
      S_TEST: begin
        if (rd_data_q != '0) begin
          out_valid_d         = 1'b1;
          out_d.popped_ref    = rd_data_q;
          out_d.found         = 1'b1;
          out_d.push_accepted = 1'b0;
          out_d.all_empty     = empty_q;
          out_d.drop_count    = drop_q;
          state_d             = S_IDLE;
        end else begin
          state_d = S_WALK;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cursor_q    <= '0;
      tries_q     <= '0;
      empty_q     <= 1'b1;
      drop_q      <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < NUM_QUEUES; i++) begin
        height_q[i] <= '0;
      end
    end else begin
      state_q     <= state_d;
      cursor_q    <= cursor_d;
      tries_q     <= tries_d;
      empty_q     <= empty_d;
      drop_q      <= drop_d;
      out_valid_q <= out_valid_d;
      height_q    <= height_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    out_q <= out_d;
  end

  // stack memory, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      stack_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_q <= stack_mem[mem_raddr];
    end
  end

endmodule

@@ sv/round_robin_multi_stack_drain_unit.sv @@
// Round-robin multi-stack drain unit: one bounded LIFO of 32-bit references per
// producer stack, pushed by queue_id (tuser 0), drained round robin by pops
// (tuser 1) that skip null entries, and slot clears to null (tuser 2). Items
// enter a two-entry command queue, so the input keeps accepting while the
// engine works and while a result waits on the output, until the queue is
// full. A pop removes entries from the stack under the cursor through a
// registered stack memory read and moves past each stack it finds empty. The
// stack memory is not cleared after reset; only slots below a stack's height
// are read. The user must see that active_queues is written through the cfg
// channel only while idle; the block itself does not enforce it.
// depends on rrmsd_pkg, rrmsd_front, rrmsd_cmd_fifo, rrmsd_back
module round_robin_multi_stack_drain_unit #(
  parameter int NUM_QUEUES  = 8,
  parameter int QUEUE_DEPTH = 1024
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [rrmsd_pkg::AQ_W-1:0]           cfg_data_i,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // queue_id [2:0], ref_value [34:3], slot_index [44:35], zero fill
  input  logic [rrmsd_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  // req_type [1:0]
  input  logic [rrmsd_pkg::REQ_W-1:0]          s_axis_tuser,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // popped_ref [31:0], found [32], push_accepted [33], all_empty [34],
  // drop_count [66:35], zero fill
  output logic [rrmsd_pkg::OUT_DATA_W-1:0]     m_axis_tdata
);

  localparam int CW = $clog2(NUM_QUEUES + 1);

  logic [rrmsd_pkg::AQ_W-1:0] active_q;
  logic [CW-1:0]              live_count;
  logic                       fifo_push, fifo_full, fifo_pop;
  rrmsd_pkg::cmd_t            fifo_cmd;
  rrmsd_pkg::cmd_chan_t       head;
  rrmsd_pkg::rsp_t            rsp;

  assign cfg_ready_o = 1'b1;

  // active stack count register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= rrmsd_pkg::AQ_W'(8);
    end else if (cfg_valid_i) begin
      active_q <= cfg_data_i;
    end
  end

  // zero acts as one, values past the stack count saturate
  always_comb begin
    if (active_q == '0) begin
      live_count = CW'(1);
    end else if (32'(active_q) > NUM_QUEUES) begin
      live_count = CW'(NUM_QUEUES);
    end else begin
      live_count = CW'(active_q);
    end
  end

  rrmsd_front #(
    .CW (CW)
  ) u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .live_count_i  (live_count),
    .fifo_full_i   (fifo_full),
    .fifo_push_o   (fifo_push),
    .fifo_cmd_o    (fifo_cmd)
  );

  rrmsd_cmd_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (fifo_push),
    .cmd_i  (fifo_cmd),
    .full_o (fifo_full),
    .head_o (head),
    .pop_i  (fifo_pop)
  );

  rrmsd_back #(
    .NUM_QUEUES  (NUM_QUEUES),
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .CW          (CW)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .live_count_i  (live_count),
    .head_i        (head),
    .pop_o         (fifo_pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .rsp_o         (rsp)
  );

  assign m_axis_tdata = {5'b0, rsp.drop_count, rsp.all_empty, rsp.push_accepted,
                         rsp.found, rsp.popped_ref};

endmodule

@@ sv/rrmsd_checker.sv @@
// port-level checks of the round-robin multi-stack drain unit, with its bind
// depends on rrmsd_pkg and round_robin_multi_stack_drain_unit_defines.svh
`include "round_robin_multi_stack_drain_unit_defines.svh"

module rrmsd_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [rrmsd_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

  `RRMSD_ASSERT(a_found_nonnull, clk_i, rst_ni,
                m_axis_tvalid && m_axis_tdata[32] |-> m_axis_tdata[31:0] != '0,
                "found result carries a null reference")
  `RRMSD_ASSERT(a_found_or_push, clk_i, rst_ni,
                m_axis_tvalid |-> !(m_axis_tdata[32] && m_axis_tdata[33]),
                "result flags both a pop hit and a stored push")
  `RRMSD_ASSERT(a_push_not_empty, clk_i, rst_ni,
                m_axis_tvalid && m_axis_tdata[33] |-> !m_axis_tdata[34],
                "stored push reports the empty flag")
  `RRMSD_ASSERT(a_out_hold, clk_i, rst_ni,
                m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata),
                "stalled result changed")
  `RRMSD_ASSERT_ALWAYS(a_reset_quiet, clk_i, !rst_ni |-> !m_axis_tvalid,
                       "result valid during reset")

endmodule

bind round_robin_multi_stack_drain_unit rrmsd_checker u_rrmsd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
